FILE: rtl/core/bfwa_pkg.sv
// Shared constants, codes and types for the bounded FIFO window average block.
package bfwa_pkg;

  localparam int CAPACITY = 5;

  localparam int TAG_W  = 16;
  localparam int YEAR_W = 12;
  localparam int STAT_W = 2;
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int SUM_W  = YEAR_W + CNT_W;
  localparam int STEP_W = $clog2(SUM_W + 1);

  typedef enum logic [0:0] {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_APPLY,
    S_DIV,
    S_DONE
  } state_t;

endpackage

FILE: rtl/core/bounded_fifo_window_average.sv
// Bounded FIFO with running sum and a bit-serial divider for the window average.
//
// Usage: an insert or remove transaction is taken at a rising edge with start
// high and busy low; action, item_tag and year_value are sampled there. busy
// then stays high until the result has been shown.
// Each transaction gives exactly one result: done is high for one cycle and
// status, removed_tag and year_average are valid in that cycle only.
//   status ST_INSERTED: year_average is the truncated mean of held years.
//   status ST_REMOVED : removed_tag is the oldest entry's tag, now dropped.
//   status ST_EMPTY   : remove on an empty FIFO; nothing changes.
// An insert on a full FIFO silently drops the oldest entry first.
// A remove passes through S_READ, S_APPLY and S_DONE from accept to done; an
// insert also runs S_DIV, the restoring divider that produces one quotient
// bit per cycle, before S_DONE. busy drops the cycle after done, so a new
// transaction can be taken in the cycle after the result.
// The receiver cannot stall: results are not held or repeated.
// Reset (rst, synchronous) empties the FIFO and zeroes the sum; the entry
// storage itself is not cleared, as unwritten slots are never read.
module bounded_fifo_window_average (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        action,
  input  logic [bfwa_pkg::TAG_W-1:0]  item_tag,
  input  logic [bfwa_pkg::YEAR_W-1:0] year_value,
  output logic                        done,
  output logic [bfwa_pkg::STAT_W-1:0] status,
  output logic [bfwa_pkg::TAG_W-1:0]  removed_tag,
  output logic [bfwa_pkg::YEAR_W-1:0] year_average
);
  import bfwa_pkg::*;

  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
  localparam logic [IDX_W:0]   CAP_WIDE = (IDX_W + 1)'(CAPACITY);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  state_t state, state_next;

  logic [TAG_W-1:0]  tag_mem  [CAPACITY];
  logic [YEAR_W-1:0] year_mem [CAPACITY];
  logic [TAG_W-1:0]  rd_tag;
  logic [YEAR_W-1:0] rd_year;

  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] sum;

  logic              req_action;
  logic [TAG_W-1:0]  req_tag;
  logic [YEAR_W-1:0] req_year;

  logic [SUM_W-1:0]  quot;
  logic [CNT_W-1:0]  rem;
  logic [STEP_W-1:0] step;

  logic [STAT_W-1:0] res_status;
  logic [TAG_W-1:0]  res_tag;
  logic [YEAR_W-1:0] res_avg;

  logic             full;
  logic [IDX_W:0]   tail_wide;
  logic [IDX_W-1:0] tail;
  logic [IDX_W-1:0] head_inc;
  logic [SUM_W-1:0] sum_ins;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   shifted;
  logic             take;
  logic [SUM_W-1:0] quot_next;
  logic [CNT_W-1:0] rem_next;

  // Slot arithmetic: operands stay below twice the capacity, so one subtract wraps.
  always_comb begin
    full      = (count == CAP_CNT);
    tail_wide = (IDX_W + 1)'(head) + (IDX_W + 1)'(count);
    if (tail_wide >= CAP_WIDE) begin
      tail_wide = tail_wide - CAP_WIDE;
    end
    tail     = full ? head : tail_wide[IDX_W-1:0];
    head_inc = (head == IDX_W'(CAPACITY - 1)) ? '0 : head + IDX_W'(1);
    sum_ins  = sum - (full ? SUM_W'(rd_year) : '0) + SUM_W'(req_year);
  end

  // One restoring division step per cycle.
  always_comb begin
    shifted   = {rem, quot[SUM_W-1]};
    trial     = shifted - {1'b0, count};
    take      = (shifted >= {1'b0, count});
    rem_next  = take ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
    quot_next = {quot[SUM_W-2:0], take};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = S_READ;
      S_READ:  state_next = S_APPLY;
      S_APPLY: state_next = (req_action == ACT_INSERT) ? S_DIV : S_DONE;
      S_DIV:   if (step == LAST_STEP) state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy         = (state != S_IDLE);
    done         = (state == S_DONE);
    status       = res_status;
    removed_tag  = res_tag;
    year_average = res_avg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Entry storage: registered read at the head slot, write at the tail slot.
  always_ff @(posedge clk) begin
    rd_tag  <= tag_mem[head];
    rd_year <= year_mem[head];
    if (state == S_APPLY && req_action == ACT_INSERT) begin
      tag_mem[tail]  <= req_tag;
      year_mem[tail] <= req_year;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      sum   <= '0;
    end else if (state == S_APPLY) begin
      if (req_action == ACT_INSERT) begin
        sum <= sum_ins;
        if (full) begin
          head <= head_inc;
        end else begin
          count <= count + CNT_W'(1);
        end
      end else if (count != '0) begin
        sum   <= sum - SUM_W'(rd_year);
        head  <= head_inc;
        count <= count - CNT_W'(1);
      end
    end
  end

  // Request capture, divider and result registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      req_action <= action;
      req_tag    <= item_tag;
      req_year   <= year_value;
    end
    unique case (state)
      S_APPLY: begin
        quot <= sum_ins;
        rem  <= '0;
        step <= '0;
        res_tag <= '0;
        res_avg <= '0;
        if (req_action == ACT_INSERT) begin
          res_status <= ST_INSERTED;
        end else if (count == '0) begin
          res_status <= ST_EMPTY;
        end else begin
          res_status <= ST_REMOVED;
          res_tag    <= rd_tag;
        end
      end
      S_DIV: begin
        quot <= quot_next;
        rem  <= rem_next;
        step <= step + STEP_W'(1);
        if (step == LAST_STEP) begin
          res_avg <= quot_next[YEAR_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/core/bfwa_checker.sv
// Port-level checker for the bounded FIFO window average block, with its bind.
module bfwa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic [bfwa_pkg::STAT_W-1:0] status,
  input logic [bfwa_pkg::TAG_W-1:0]  removed_tag,
  input logic [bfwa_pkg::YEAR_W-1:0] year_average
);
  import bfwa_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted transaction");

  a_done_in_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside a busy period");

  a_done_releases: assert property (@(posedge clk) disable iff (rst)
    done |=> (!busy && !done))
    else $error("block did not return to idle after a result");

  a_tag_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_REMOVED) |-> (removed_tag == '0))
    else $error("removed_tag nonzero on a result without a removal");

  a_avg_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_INSERTED) |-> (year_average == '0))
    else $error("year_average nonzero on a result without an insert");

endmodule

bind bounded_fifo_window_average bfwa_checker u_bfwa_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .status       (status),
  .removed_tag  (removed_tag),
  .year_average (year_average)
);

FILE: sim/bfwa_result_check.sv
`timescale 1ns / 1ps
// Result checker for the FIFO window average block: predicts each transaction and compares.
module bfwa_result_check (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        action,
  input  logic [bfwa_pkg::TAG_W-1:0]  item_tag,
  input  logic [bfwa_pkg::YEAR_W-1:0] year_value,
  input  logic                        done,
  input  logic [bfwa_pkg::STAT_W-1:0] status,
  input  logic [bfwa_pkg::TAG_W-1:0]  removed_tag,
  input  logic [bfwa_pkg::YEAR_W-1:0] year_average,
  output int                          errors,
  output int                          pending
);
  import bfwa_pkg::*;

  typedef struct packed {
    status_t            status;
    logic [TAG_W-1:0]   tag;
    logic [YEAR_W-1:0]  avg;
  } window_reply_t;

  // Shadow copy of the FIFO
  logic [TAG_W-1:0]  tag_mem [CAPACITY];
  logic [YEAR_W-1:0] year_mem [CAPACITY];
  logic [IDX_W-1:0]  head = '0;
  logic [CNT_W-1:0]  held = '0;
  logic [SUM_W-1:0]  year_total = '0;

  window_reply_t window_replies_q [$];
  window_reply_t want;

  initial begin
    errors  = 0;
    pending = 0;
    for (int i = 0; i < CAPACITY; i++) begin
      tag_mem[i]  = '0;
      year_mem[i] = '0;
    end
  end

  function automatic void drop_oldest();
    year_total = year_total - SUM_W'(year_mem[head]);
    head = (head == IDX_W'(CAPACITY - 1)) ? '0 : head + IDX_W'(1);
    held = held - CNT_W'(1);
  endfunction

  function automatic void window_step(input action_t act, input logic [TAG_W-1:0] tag,
                                      input logic [YEAR_W-1:0] yr);
    window_reply_t    r;
    logic [IDX_W-1:0] slot;
    logic [SUM_W-1:0] quot;
    r.status = ST_INSERTED;
    r.tag    = '0;
    r.avg    = '0;
    if (act == ACT_INSERT) begin
      // full: oldest goes away silently, its tag is not reported
      if (held == CNT_W'(CAPACITY)) drop_oldest();
      slot = IDX_W'((int'(head) + int'(held)) % CAPACITY);
      tag_mem[slot]  = tag;
      year_mem[slot] = yr;
      year_total = year_total + SUM_W'(yr);
      held = held + CNT_W'(1);
      quot = year_total / SUM_W'(held);
      r.avg = quot[YEAR_W-1:0];
    end else if (held == '0) begin
      r.status = ST_EMPTY;
    end else begin
      r.status = ST_REMOVED;
      r.tag    = tag_mem[head];
      drop_oldest();
    end
    window_replies_q.push_back(r);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      head = '0;
      held = '0;
      year_total = '0;
      window_replies_q.delete();
    end else begin
      if (done) begin
        if (window_replies_q.size() == 0) begin
          $error("result with no transaction outstanding: status %0d", status);
          errors++;
        end else begin
          want = window_replies_q.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
          end
          if (removed_tag !== want.tag) begin
            $error("removed_tag: expected %0h, got %0h", want.tag, removed_tag);
            errors++;
          end
          if (year_average !== want.avg) begin
            $error("year_average: expected %0d, got %0d", want.avg, year_average);
            errors++;
          end
        end
      end
      if (start && !busy) window_step(action_t'(action), item_tag, year_value);
    end
    pending = window_replies_q.size();
  end

endmodule

FILE: sim/bounded_fifo_window_average_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives insert/remove transactions into the window average block.
module bounded_fifo_window_average_tb;
  import bfwa_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              action = 1'b0;
  logic [TAG_W-1:0]  item_tag = '0;
  logic [YEAR_W-1:0] year_value = '0;
  logic              busy;
  logic              done;
  logic [STAT_W-1:0] status;
  logic [TAG_W-1:0]  removed_tag;
  logic [YEAR_W-1:0] year_average;
  int                errors;
  int                pending;
  bit                no_idle = 1'b0;

  always #10 clk = ~clk;

  bounded_fifo_window_average dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .item_tag     (item_tag),
    .year_value   (year_value),
    .done         (done),
    .status       (status),
    .removed_tag  (removed_tag),
    .year_average (year_average)
  );

  bfwa_result_check window_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .item_tag     (item_tag),
    .year_value   (year_value),
    .done         (done),
    .status       (status),
    .removed_tag  (removed_tag),
    .year_average (year_average),
    .errors       (errors),
    .pending      (pending)
  );

  // start stays high across back-to-back transactions
  task automatic issue_op(input action_t act, input logic [TAG_W-1:0] tag,
                          input logic [YEAR_W-1:0] yr);
    int gap;
    gap = no_idle ? 0 : int'($urandom_range(17, 0));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    action     <= act;
    item_tag   <= tag;
    year_value <= yr;
    do @(posedge clk); while (busy);
  endtask

  // extremes now and then, uniform otherwise
  function automatic logic [TAG_W-1:0] pick_field(input int bits);
    logic [TAG_W-1:0] mask;
    mask = TAG_W'((1 << bits) - 1);
    case ($urandom_range(15, 0))
      0:       return '0;
      1:       return mask;
      default: return TAG_W'($urandom) & mask;
    endcase
  endfunction

  initial begin
    int      insert_pct;
    action_t op;
    insert_pct = 50;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty remove, extremes, fill, evict on full, drain, wrap
    issue_op(ACT_REMOVE, 16'hFFFF, 12'hFFF);
    issue_op(ACT_INSERT, 16'h0000, 12'd0);
    issue_op(ACT_INSERT, 16'hFFFF, 12'd4095);
    issue_op(ACT_INSERT, 16'h5555, 12'd4095);
    issue_op(ACT_INSERT, 16'hAAAA, 12'd4095);
    issue_op(ACT_INSERT, 16'h1234, 12'd4095);
    issue_op(ACT_INSERT, 16'h8001, 12'd4095);
    issue_op(ACT_INSERT, 16'h7FFE, 12'd0);
    repeat (5) issue_op(ACT_REMOVE, 16'h0000, 12'd0);
    issue_op(ACT_REMOVE, 16'h0000, 12'd0);
    issue_op(ACT_INSERT, 16'h00FF, 12'd7);
    issue_op(ACT_INSERT, 16'hFF00, 12'd2048);
    issue_op(ACT_REMOVE, 16'hFFFF, 12'hFFF);
    issue_op(ACT_INSERT, 16'h0F0F, 12'd2047);
    issue_op(ACT_INSERT, 16'hF0F0, 12'd1);
    issue_op(ACT_REMOVE, 16'h0000, 12'd0);
    issue_op(ACT_REMOVE, 16'h0000, 12'd0);
    issue_op(ACT_REMOVE, 16'h0000, 12'd0);

    // random: insert mix and idling change every few dozen transactions
    for (int n = 0; n < 1000; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2, 0))
          0:       insert_pct = 25;
          1:       insert_pct = 50;
          default: insert_pct = 80;
        endcase
        no_idle = ($urandom_range(3, 0) == 0);
      end
      op = ($urandom_range(99, 0) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
      issue_op(op, pick_field(TAG_W), YEAR_W'(pick_field(YEAR_W)));
    end
    start <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (errors == 0) begin
      $display("bounded_fifo_window_average_tb: clean");
    end else begin
      $display("bounded_fifo_window_average_tb: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("bounded_fifo_window_average_tb: errors");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/bfwa_pkg.sv
rtl/core/bounded_fifo_window_average.sv
rtl/core/bfwa_checker.sv
sim/bfwa_result_check.sv
sim/bounded_fifo_window_average_tb.sv
